// ===== hw/rtl/bresenham_line_points_macros.svh =====
// Assertion macros used by the checker module of the line rasterizer.
`ifndef BRESENHAM_LINE_POINTS_MACROS_SVH
`define BRESENHAM_LINE_POINTS_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define BLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/blp_pkg.sv =====
// Shared types and constants of the line rasterizer.
package blp_pkg;

    localparam int DEF_COORD_BITS = 6;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture a new request and set up the walk
        logic step;   // push the current cell out and advance
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;      // current cell is the end cell
        logic out_free;  // output register can take a cell this cycle
    } t_dp_stat;

endpackage

// ===== hw/rtl/blp_ctrl.sv =====
// Controller state machine of the line rasterizer.
module blp_ctrl
    import blp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step = (r_state == S_RUN) && i_stat.out_free;
        o_in_stall = (r_state != S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // drop back to idle once the end cell is pushed
                if (i_stat.out_free && i_stat.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/blp_datapath.sv =====
// Datapath of the line rasterizer: walk registers and output register.
module blp_datapath
    import blp_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_cell_x,
    output logic [COORD_BITS-1:0] o_cell_y,
    output logic                  o_last_point
);

    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + 3;

    // walk state
    logic [W-1:0]         r_x, r_y, r_cnt, r_major, r_minor;
    logic signed [DW-1:0] r_d;
    logic                 r_x_major, r_sx_neg, r_sy_neg;

    // output register
    logic                 r_out_valid;
    logic [W-1:0]         r_cell_x, r_cell_y;
    logic                 r_last_point;

    // setup terms
    logic [W:0]           dx, dy;
    logic [W-1:0]         adx, ady, ld_major, ld_minor;
    logic                 ld_x_major;
    logic signed [DW-1:0] ld_d;

    // step terms
    logic                 d_ge;
    logic                 step_x, step_y;
    logic signed [DW-1:0] two_minor, two_major, n_d;
    logic [W-1:0]         n_x, n_y;

    always_comb begin
        dx = {1'b0, i_end_x} - {1'b0, i_start_x};
        dy = {1'b0, i_end_y} - {1'b0, i_start_y};
        adx = dx[W] ? W'(-dx) : dx[W-1:0];
        ady = dy[W] ? W'(-dy) : dy[W-1:0];
        ld_x_major = (adx > ady);
        ld_major = ld_x_major ? adx : ady;
        ld_minor = ld_x_major ? ady : adx;
        ld_d = $signed({2'b00, ld_minor, 1'b0}) - $signed({3'b000, ld_major});
    end

    always_comb begin
        two_minor = $signed({2'b00, r_minor, 1'b0});
        two_major = $signed({2'b00, r_major, 1'b0});
        d_ge = !r_d[DW-1];
        n_d = d_ge ? (r_d + two_minor - two_major) : (r_d + two_minor);
        step_x = r_x_major || d_ge;
        step_y = !r_x_major || d_ge;
        n_x = step_x ? (r_sx_neg ? r_x - W'(1) : r_x + W'(1)) : r_x;
        n_y = step_y ? (r_sy_neg ? r_y - W'(1) : r_y + W'(1)) : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x       <= i_start_x;
            r_y       <= i_start_y;
            r_cnt     <= ld_major;
            r_major   <= ld_major;
            r_minor   <= ld_minor;
            r_d       <= ld_d;
            r_x_major <= ld_x_major;
            // zero span counts as negative; that axis never moves
            r_sx_neg  <= dx[W] || (dx == '0);
            r_sy_neg  <= dy[W] || (dy == '0);
        end else if (i_cmd.step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_d   <= n_d;
            r_cnt <= r_cnt - W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_cell_x     <= r_x;
            r_cell_y     <= r_y;
            r_last_point <= (r_cnt == '0);
        end
    end

    assign o_stat.last     = (r_cnt == '0);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_cell_x     = r_cell_x;
    assign o_cell_y     = r_cell_y;
    assign o_last_point = r_last_point;

endmodule

// ===== hw/rtl/bresenham_line_points.sv =====
// Top level of the Bresenham line rasterizer.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_start_x i_start_y i_end_x i_end_y
//   out     | output    | o_out_valid / i_out_stall| o_cell_x o_cell_y o_last_point
//
// A request is captured and the walk set up in the idle state; then the walk gives
// one cell per cycle while the output does not stall, set by the single
// step of the walk registers feeding the output register.
// Reset (i_rst_n, synchronous) clears the controller and the output valid.
// An output stall holds the walk; the next request is taken while the end
// cell still waits in the output register.
module bresenham_line_points
    import blp_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_cell_x,
    output logic [COORD_BITS-1:0] o_cell_y,
    output logic                  o_last_point
);

    // commands down, status up
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequence the request: idle, then walk until the end cell is pushed
    blp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold the walk state and the output register
    blp_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_last_point (o_last_point)
    );

endmodule

// ===== hw/rtl/blp_checker.sv =====
// Port-level checker of the line rasterizer and its bind.
`include "bresenham_line_points_macros.svh"

module blp_checker
    import blp_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [COORD_BITS-1:0] i_start_x,
    input logic [COORD_BITS-1:0] i_start_y,
    input logic [COORD_BITS-1:0] i_end_x,
    input logic [COORD_BITS-1:0] i_end_y,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [COORD_BITS-1:0] o_cell_x,
    input logic [COORD_BITS-1:0] o_cell_y,
    input logic                  o_last_point
);

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // a stalled request holds
    `BLP_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall,
        i_in_valid && $stable(i_start_x) && $stable(i_start_y) && $stable(i_end_x) && $stable(i_end_y))
    // a stalled result holds
    `BLP_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_cell_x) && $stable(o_cell_y) && $stable(o_last_point))
    // a taken request makes the block busy
    `BLP_ASSERT_NEXT(a_busy_after_take, in_take, o_in_stall)
    // no new request while a line is only partly out
    `BLP_ASSERT_NOW(a_busy_mid_line, o_out_valid && !o_last_point, o_in_stall)
    // a taken inner cell is followed at once by the next cell
    `BLP_ASSERT_NEXT(a_no_gap, o_out_valid && !i_out_stall && !o_last_point, o_out_valid)

endmodule

bind bresenham_line_points blp_checker #(.COORD_BITS(COORD_BITS)) u_blp_checker (.*);
